@@ rtl/pmp_pkg.sv @@
// Shared types, constants and command/status structures for the polygon
// mass properties block. No dependencies; every other RTL file imports it.
`default_nettype none
package pmp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 2);

    localparam int CRD_W   = 14;   // vertex coordinate, signed Q5.8
    localparam int CR_W    = 29;   // edge cross product, signed
    localparam int ACR_W   = 28;   // magnitude of the edge cross product
    localparam int SUM_W   = 35;   // signed cross sum
    localparam int CSUM_W  = 49;   // centroid sums
    localparam int NUM_W   = 62;   // inertia numerator
    localparam int DEN_W   = 34;   // inertia denominator
    localparam int DOT_W   = 31;   // dot-product sum of one edge
    localparam int TRN_W   = 31;   // corner turn terms
    localparam int MUL_W   = 32;   // shared multiplier operand width
    localparam int PRD_W   = 64;   // shared multiplier product width
    localparam int MP_W    = 47;   // mass times a 31-bit slice of the numerator
    localparam int NI_W    = 78;   // mass times numerator
    localparam int UD_W    = 36;   // magnitude of three times the cross sum
    localparam int DV_W    = 53;   // six times denominator, scaled by 2^16
    localparam int DIVN_W  = 80;   // divider dividend width
    localparam int DIVD_W  = 54;   // divider divisor width
    localparam int DCNT_W  = $clog2(DIVN_W + 1);
    localparam int AREA_W  = 33;
    localparam int INER_W  = 48;
    localparam int MASS_W  = 16;
    localparam logic [MASS_W-1:0] MASS_RESET = 16'd256;

    typedef enum logic [3:0] {
        MO_NONE, MO_AXBY, MO_BXAY, MO_SXCR, MO_SYCR, MO_AXAX, MO_AYAY,
        MO_AXBX, MO_AYBY, MO_BXBX, MO_BYBY, MO_ACRDOT, MO_C1, MO_C2,
        MO_MLO, MO_MHI
    } mul_op_t;

    typedef enum logic [3:0] {
        AO_NONE, AO_P1, AO_CR, AO_CX, AO_CY, AO_DOT0, AO_DOT, AO_NUM,
        AO_T, AO_TURN, AO_MLO, AO_MHI
    } acc_op_t;

    typedef enum logic [1:0] {
        CS_VTX, CS_CL1, CS_CL2
    } csel_t;

    typedef enum logic [1:0] {
        DS_X, DS_Y, DS_I
    } div_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISP, ST_E0, ST_E1, ST_E2, ST_E3, ST_E4, ST_E5, ST_E6,
        ST_E7, ST_E8, ST_E9, ST_E10, ST_E11, ST_NUM, ST_C1, ST_C2, ST_TURN,
        ST_UPD, ST_M0, ST_M1, ST_M2, ST_DX, ST_WX, ST_DY, ST_WY, ST_DI,
        ST_WI, ST_FIN
    } state_t;

    typedef struct packed {
        mul_op_t  mul_op;
        acc_op_t  acc_op;
        logic     close;
        csel_t    csel;
        logic     corner_first;
        logic     load_in;
        logic     cnt_sat;
        logic     update;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_x;
        logic     cap_y;
        logic     load_out;
        logic     clear;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_two;
        logic cnt_ge3;
        logic cnt_full;
        logic last;
        logic div_busy;
        logic out_busy;
    } dp_sts_t;

endpackage
`default_nettype wire

@@ rtl/pmp_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pmp_pkg for its widths.
`default_nettype none
module pmp_div (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire  [pmp_pkg::DIVN_W-1:0]   dividend,
    input  wire  [pmp_pkg::DIVD_W-1:0]   divisor,
    output logic                         busy,
    output logic [pmp_pkg::DIVN_W-1:0]   quotient
);
    import pmp_pkg::*;

    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVD_W:0]   rem_reg, rem_next;
    logic [DIVN_W-1:0] quo_reg, quo_next;
    logic [DIVD_W-1:0] dsr_reg, dsr_next;
    logic [DIVD_W:0]   rem_sh;
    logic              fits;

    always_comb
    begin
        rem_sh   = {rem_reg[DIVD_W-1:0], quo_reg[DIVN_W-1]};
        fits     = rem_sh >= {1'b0, dsr_reg};
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            cnt_next = DCNT_W'(DIVN_W);
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? rem_sh - {1'b0, dsr_reg} : rem_sh;
            quo_next = {quo_reg[DIVN_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

@@ rtl/pmp_datapath.sv @@
// Datapath: vertex history, running sums, shared multiplier, divider and
// the result register. Depends on pmp_pkg and pmp_div.
`default_nettype none
module pmp_datapath (
    input  wire                                clk,
    input  wire                                rst_n,
    input  pmp_pkg::dp_cmd_t                   cmd,
    output pmp_pkg::dp_sts_t                   sts,
    input  wire signed [pmp_pkg::CRD_W-1:0]    vertex_x,
    input  wire signed [pmp_pkg::CRD_W-1:0]    vertex_y,
    input  wire                                last_vertex,
    input  wire                                cfg_we,
    input  wire        [pmp_pkg::MASS_W-1:0]   cfg_data,
    input  wire                                out_stall,
    output logic                               out_valid,
    output logic       [pmp_pkg::AREA_W-1:0]   area,
    output logic signed [pmp_pkg::CRD_W-1:0]   centroid_x,
    output logic signed [pmp_pkg::CRD_W-1:0]   centroid_y,
    output logic       [pmp_pkg::INER_W-1:0]   inertia,
    output logic                               is_convex,
    output logic                               too_few_vertices,
    output logic                               degenerate,
    output logic                               too_many_vertices
);
    import pmp_pkg::*;

    logic [MASS_W-1:0]       mass_reg;
    logic signed [CRD_W-1:0] vx_reg, vy_reg, fx_reg, fy_reg, sx_reg, sy_reg;
    logic signed [CRD_W-1:0] px_reg, py_reg, bx_reg, by_reg;
    logic                    last_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [CSUM_W-1:0] csx_reg, csy_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [DEN_W-1:0]        den_reg;
    logic                    ref_pos_reg, ref_neg_reg, convex_reg;
    logic signed [CR_W-1:0]  p1_reg, cr_reg;
    logic signed [DOT_W-1:0] dots_reg;
    logic signed [TRN_W-1:0] t_reg;
    logic signed [PRD_W-1:0] prod_reg;
    logic [MP_W-1:0]         mlo_reg;
    logic [NI_W-1:0]         ni_reg;
    logic [DV_W-1:0]         dv_reg;
    logic [UD_W-1:0]         ud_reg;
    logic signed [CRD_W-1:0] cx_reg, cy_reg;
    logic                    out_valid_reg;

    // Operand selection for the edge and the corner.
    logic signed [CRD_W-1:0] ea_x, ea_y, eb_x, eb_y;
    logic signed [CRD_W-1:0] ca_x, ca_y, cb_x, cb_y, cc_x, cc_y;
    logic signed [MUL_W-1:0] ma, mb;
    logic signed [CR_W-1:0]  cr_n;
    logic [CR_W-1:0]         acr_n, acr_r;
    logic signed [TRN_W-1:0] turn;
    logic                    t_pos, t_neg;
    logic signed [UD_W-1:0]  d3;
    logic [CSUM_W-1:0]       unx, uny;
    logic [DIVN_W-1:0]       div_n;
    logic [DIVD_W-1:0]       div_d;
    logic                    div_busy;
    logic [DIVN_W-1:0]       quo;
    logic signed [CRD_W-1:0] cap_val;
    logic                    cap_neg;
    logic [SUM_W-1:0]        sum_mag;
    logic [SUM_W:0]          area_rnd;
    logic                    many;

    always_comb
    begin
        ea_x = px_reg;
        ea_y = py_reg;
        eb_x = cmd.close ? fx_reg : vx_reg;
        eb_y = cmd.close ? fy_reg : vy_reg;
        unique case (cmd.csel)
            CS_VTX:
            begin
                ca_x = bx_reg; ca_y = by_reg; cb_x = px_reg; cb_y = py_reg;
                cc_x = vx_reg; cc_y = vy_reg;
            end
            CS_CL1:
            begin
                ca_x = bx_reg; ca_y = by_reg; cb_x = px_reg; cb_y = py_reg;
                cc_x = fx_reg; cc_y = fy_reg;
            end
            default:
            begin
                ca_x = px_reg; ca_y = py_reg; cb_x = fx_reg; cb_y = fy_reg;
                cc_x = sx_reg; cc_y = sy_reg;
            end
        endcase
    end

    always_comb
    begin
        acr_r = cr_reg[CR_W-1] ? CR_W'(-cr_reg) : CR_W'(cr_reg);
        case (cmd.mul_op)
            MO_AXBY:   begin ma = MUL_W'(ea_x); mb = MUL_W'(eb_y); end
            MO_BXAY:   begin ma = MUL_W'(eb_x); mb = MUL_W'(ea_y); end
            MO_SXCR:   begin ma = MUL_W'(16'(ea_x) + 16'(eb_x)); mb = MUL_W'(cr_reg); end
            MO_SYCR:   begin ma = MUL_W'(16'(ea_y) + 16'(eb_y)); mb = MUL_W'(cr_reg); end
            MO_AXAX:   begin ma = MUL_W'(ea_x); mb = MUL_W'(ea_x); end
            MO_AYAY:   begin ma = MUL_W'(ea_y); mb = MUL_W'(ea_y); end
            MO_AXBX:   begin ma = MUL_W'(ea_x); mb = MUL_W'(eb_x); end
            MO_AYBY:   begin ma = MUL_W'(ea_y); mb = MUL_W'(eb_y); end
            MO_BXBX:   begin ma = MUL_W'(eb_x); mb = MUL_W'(eb_x); end
            MO_BYBY:   begin ma = MUL_W'(eb_y); mb = MUL_W'(eb_y); end
            MO_ACRDOT: begin ma = $signed({3'b000, acr_r}); mb = MUL_W'(dots_reg); end
            MO_C1:
            begin
                ma = MUL_W'(16'(cb_x) - 16'(ca_x));
                mb = MUL_W'(16'(cc_y) - 16'(cb_y));
            end
            MO_C2:
            begin
                ma = MUL_W'(16'(cb_y) - 16'(ca_y));
                mb = MUL_W'(16'(cc_x) - 16'(cb_x));
            end
            MO_MLO:    begin ma = $signed({16'd0, mass_reg}); mb = $signed({1'b0, num_reg[30:0]}); end
            MO_MHI:    begin ma = $signed({16'd0, mass_reg}); mb = $signed({1'b0, num_reg[61:31]}); end
            default:   begin ma = '0; mb = '0; end
        endcase
    end

    always_comb
    begin
        cr_n  = p1_reg - prod_reg[CR_W-1:0];
        acr_n = cr_n[CR_W-1] ? CR_W'(-cr_n) : CR_W'(cr_n);
        turn  = t_reg - prod_reg[TRN_W-1:0];
        t_neg = turn[TRN_W-1];
        t_pos = !turn[TRN_W-1] && (turn != '0);
        d3    = (UD_W'(sum_reg) <<< 1) + UD_W'(sum_reg);
        unx   = csx_reg[CSUM_W-1] ? CSUM_W'(-csx_reg) : CSUM_W'(csx_reg);
        uny   = csy_reg[CSUM_W-1] ? CSUM_W'(-csy_reg) : CSUM_W'(csy_reg);
        case (cmd.div_sel)
            DS_X:
            begin
                div_n = DIVN_W'({unx, 1'b0}) + DIVN_W'(ud_reg);
                div_d = DIVD_W'({ud_reg, 1'b0});
            end
            DS_Y:
            begin
                div_n = DIVN_W'({uny, 1'b0}) + DIVN_W'(ud_reg);
                div_d = DIVD_W'({ud_reg, 1'b0});
            end
            default:
            begin
                div_n = DIVN_W'({ni_reg, 1'b0}) + DIVN_W'(dv_reg);
                div_d = DIVD_W'({dv_reg, 1'b0});
            end
        endcase
        // Centroid quotient: apply the sign, then saturate to Q5.8 range.
        cap_neg = (cmd.cap_x ? csx_reg[CSUM_W-1] : csy_reg[CSUM_W-1]) ^ sum_reg[SUM_W-1];
        if (!cap_neg)
            cap_val = (quo > DIVN_W'(8191)) ? 14'sd8191 : $signed(quo[CRD_W-1:0]);
        else
            cap_val = (quo > DIVN_W'(8192)) ? -14'sd8192
                                            : $signed(CRD_W'(14'd0 - quo[CRD_W-1:0]));
        sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        area_rnd = {1'b0, sum_mag} + 1'b1;
        many     = cnt_reg > CNT_W'(MAX_VERTICES);
    end

    pmp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .busy     (div_busy),
        .quotient (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg    <= MASS_RESET;
            fx_reg <= '0; fy_reg <= '0; sx_reg <= '0; sy_reg <= '0;
            px_reg <= '0; py_reg <= '0; bx_reg <= '0; by_reg <= '0;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            csx_reg     <= '0;
            csy_reg     <= '0;
            num_reg     <= '0;
            den_reg     <= '0;
            ref_pos_reg <= 1'b0;
            ref_neg_reg <= 1'b0;
            convex_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mass_reg <= cfg_data;
            case (cmd.acc_op)
                AO_CR:
                begin
                    sum_reg <= sum_reg + SUM_W'(cr_n);
                    den_reg <= den_reg + DEN_W'(acr_n);
                end
                AO_CX:  csx_reg <= csx_reg + prod_reg[CSUM_W-1:0];
                AO_CY:  csy_reg <= csy_reg + prod_reg[CSUM_W-1:0];
                AO_NUM: num_reg <= num_reg + NUM_W'(prod_reg[NUM_W-1:0]);
                AO_TURN:
                begin
                    if (cmd.corner_first)
                    begin
                        ref_pos_reg <= t_pos;
                        ref_neg_reg <= t_neg;
                    end
                    else if ((t_pos && ref_neg_reg) || (t_neg && ref_pos_reg))
                        convex_reg <= 1'b0;
                end
                default: ;
            endcase
            if (cmd.cnt_sat)
                cnt_reg <= CNT_W'(MAX_VERTICES + 1);
            if (cmd.update)
            begin
                if (cnt_reg == '0)
                begin
                    fx_reg <= vx_reg; fy_reg <= vy_reg;
                end
                if (cnt_reg == CNT_W'(1))
                begin
                    sx_reg <= vx_reg; sy_reg <= vy_reg;
                end
                bx_reg  <= px_reg; by_reg <= py_reg;
                px_reg  <= vx_reg; py_reg <= vy_reg;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.clear)
            begin
                fx_reg <= '0; fy_reg <= '0; sx_reg <= '0; sy_reg <= '0;
                px_reg <= '0; py_reg <= '0; bx_reg <= '0; by_reg <= '0;
                cnt_reg     <= '0;
                sum_reg     <= '0;
                csx_reg     <= '0;
                csy_reg     <= '0;
                num_reg     <= '0;
                den_reg     <= '0;
                ref_pos_reg <= 1'b0;
                ref_neg_reg <= 1'b0;
                convex_reg  <= 1'b1;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        if (cmd.load_in)
        begin
            vx_reg   <= vertex_x;
            vy_reg   <= vertex_y;
            last_reg <= last_vertex;
        end
        case (cmd.acc_op)
            AO_P1:   p1_reg   <= prod_reg[CR_W-1:0];
            AO_CR:   cr_reg   <= cr_n;
            AO_DOT0: dots_reg <= prod_reg[DOT_W-1:0];
            AO_DOT:  dots_reg <= dots_reg + prod_reg[DOT_W-1:0];
            AO_T:    t_reg    <= prod_reg[TRN_W-1:0];
            AO_MLO:  mlo_reg  <= prod_reg[MP_W-1:0];
            AO_MHI:
            begin
                ni_reg <= NI_W'({prod_reg[MP_W-1:0], 31'd0}) + NI_W'(mlo_reg);
                dv_reg <= DV_W'({(37'(den_reg) << 2) + (37'(den_reg) << 1), 16'd0});
                ud_reg <= d3[UD_W-1] ? UD_W'(-d3) : UD_W'(d3);
            end
            default: ;
        endcase
        if (cmd.cap_x)
            cx_reg <= cap_val;
        if (cmd.cap_y)
            cy_reg <= cap_val;
        if (cmd.load_out)
        begin
            area              <= many ? '0 : area_rnd[AREA_W:1];
            centroid_x        <= (many || sum_reg == '0) ? '0 : cx_reg;
            centroid_y        <= (many || sum_reg == '0) ? '0 : cy_reg;
            inertia           <= (many || den_reg == '0) ? '0 :
                                 (quo[DIVN_W-1:INER_W] != '0) ? '1 : quo[INER_W-1:0];
            is_convex         <= !many && cnt_reg >= CNT_W'(3) && convex_reg;
            too_few_vertices  <= !many && cnt_reg < CNT_W'(3);
            degenerate        <= !many && den_reg == '0;
            too_many_vertices <= many;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.cnt_zero = cnt_reg == '0;
    assign sts.cnt_two  = cnt_reg == CNT_W'(2);
    assign sts.cnt_ge3  = cnt_reg >= CNT_W'(3);
    assign sts.cnt_full = cnt_reg >= CNT_W'(MAX_VERTICES);
    assign sts.last     = last_reg;
    assign sts.div_busy = div_busy;
    assign sts.out_busy = out_valid_reg && out_stall;
endmodule
`default_nettype wire

@@ rtl/pmp_ctrl.sv @@
// Sequencer that walks each vertex through the shared multiplier and
// drives the end-of-polygon divisions. Depends on pmp_pkg.
`default_nettype none
module pmp_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    input  pmp_pkg::dp_sts_t  sts,
    output pmp_pkg::dp_cmd_t  cmd
);
    import pmp_pkg::*;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;    // high while the closing edge is worked
    logic   csel2_reg, csel2_next;    // second closing corner
    logic   corner_needed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
            csel2_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            csel2_reg <= csel2_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        csel2_next = csel2_reg;
        cmd              = '0;
        cmd.mul_op       = MO_NONE;
        cmd.acc_op       = AO_NONE;
        cmd.div_sel      = DS_X;
        cmd.close        = phase_reg;
        cmd.csel         = phase_reg ? (csel2_reg ? CS_CL2 : CS_CL1) : CS_VTX;
        cmd.corner_first = !phase_reg && sts.cnt_two;
        corner_needed    = phase_reg ? sts.cnt_ge3 : (sts.cnt_two || sts.cnt_ge3);
        in_stall         = state_reg != ST_IDLE;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISP;
                end
            ST_DISP:
                if (sts.cnt_full)
                begin
                    cmd.cnt_sat = 1'b1;
                    state_next  = sts.last ? ST_FIN : ST_IDLE;
                end
                else if (sts.cnt_zero)
                    state_next = ST_UPD;
                else
                    state_next = ST_E0;
            ST_E0:  begin cmd.mul_op = MO_AXBY; state_next = ST_E1; end
            ST_E1:  begin cmd.mul_op = MO_BXAY; cmd.acc_op = AO_P1; state_next = ST_E2; end
            ST_E2:  begin cmd.mul_op = MO_AXAX; cmd.acc_op = AO_CR; state_next = ST_E3; end
            ST_E3:  begin cmd.mul_op = MO_SXCR; cmd.acc_op = AO_DOT0; state_next = ST_E4; end
            ST_E4:  begin cmd.mul_op = MO_SYCR; cmd.acc_op = AO_CX; state_next = ST_E5; end
            ST_E5:  begin cmd.mul_op = MO_AYAY; cmd.acc_op = AO_CY; state_next = ST_E6; end
            ST_E6:  begin cmd.mul_op = MO_AXBX; cmd.acc_op = AO_DOT; state_next = ST_E7; end
            ST_E7:  begin cmd.mul_op = MO_AYBY; cmd.acc_op = AO_DOT; state_next = ST_E8; end
            ST_E8:  begin cmd.mul_op = MO_BXBX; cmd.acc_op = AO_DOT; state_next = ST_E9; end
            ST_E9:  begin cmd.mul_op = MO_BYBY; cmd.acc_op = AO_DOT; state_next = ST_E10; end
            ST_E10: begin cmd.acc_op = AO_DOT; state_next = ST_E11; end
            ST_E11: begin cmd.mul_op = MO_ACRDOT; state_next = ST_NUM; end
            ST_NUM:
            begin
                cmd.acc_op = AO_NUM;
                if (corner_needed)
                    state_next = ST_C1;
                else
                    state_next = phase_reg ? ST_M0 : ST_UPD;
            end
            ST_C1:  begin cmd.mul_op = MO_C1; state_next = ST_C2; end
            ST_C2:  begin cmd.mul_op = MO_C2; cmd.acc_op = AO_T; state_next = ST_TURN; end
            ST_TURN:
            begin
                cmd.acc_op = AO_TURN;
                if (phase_reg && !csel2_reg)
                begin
                    csel2_next = 1'b1;
                    state_next = ST_C1;
                end
                else
                    state_next = phase_reg ? ST_M0 : ST_UPD;
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                if (sts.last)
                begin
                    phase_next = 1'b1;
                    csel2_next = 1'b0;
                    state_next = ST_E0;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_M0:  begin cmd.mul_op = MO_MLO; state_next = ST_M1; end
            ST_M1:  begin cmd.mul_op = MO_MHI; cmd.acc_op = AO_MLO; state_next = ST_M2; end
            ST_M2:  begin cmd.acc_op = AO_MHI; state_next = ST_DX; end
            ST_DX:  begin cmd.div_start = 1'b1; cmd.div_sel = DS_X; state_next = ST_WX; end
            ST_WX:
                if (!sts.div_busy)
                begin
                    cmd.cap_x  = 1'b1;
                    state_next = ST_DY;
                end
            ST_DY:  begin cmd.div_start = 1'b1; cmd.div_sel = DS_Y; state_next = ST_WY; end
            ST_WY:
                if (!sts.div_busy)
                begin
                    cmd.cap_y  = 1'b1;
                    state_next = ST_DI;
                end
            ST_DI:  begin cmd.div_start = 1'b1; cmd.div_sel = DS_I; state_next = ST_WI; end
            ST_WI:
            begin
                cmd.div_sel = DS_I;
                if (!sts.div_busy)
                    state_next = ST_FIN;
            end
            ST_FIN:
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    cmd.clear    = 1'b1;
                    phase_next   = 1'b0;
                    csel2_next   = 1'b0;
                    state_next   = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/polygon_mass_properties.sv @@
// Top level of the polygon mass properties block: controller, datapath and
// the body mass register port. Depends on pmp_pkg, pmp_ctrl, pmp_datapath.
`default_nettype none
// The block takes one polygon vertex per input transaction, in signed Q5.8,
// with last_vertex set on the final one, and returns a single result
// transaction per polygon: area, centroid, polar inertia for the configured
// body mass, and status flags. Each vertex after the first is worked
// through one shared 32x32 multiplier by a sequencer, first for the edge
// sums and then, from the third vertex on, for the corner turn, during
// which input is stalled.
// The final vertex adds the closing edge and two wrap-around corners, then
// runs three restoring divisions of 80 quotient bits on a shared divider.
// Vertices beyond 64 are dropped and flagged. A finished result waits in
// the output register while the next polygon's vertices are taken; only
// the next result waits for it to drain. body_mass is written through the
// cfg channel, which is always ready, and should only change while no
// polygon is in progress.
module polygon_mass_properties (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire signed [pmp_pkg::CRD_W-1:0]    vertex_x,
    input  wire signed [pmp_pkg::CRD_W-1:0]    vertex_y,
    input  wire                                last_vertex,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic       [pmp_pkg::AREA_W-1:0]   area,
    output logic signed [pmp_pkg::CRD_W-1:0]   centroid_x,
    output logic signed [pmp_pkg::CRD_W-1:0]   centroid_y,
    output logic       [pmp_pkg::INER_W-1:0]   inertia,
    output logic                               is_convex,
    output logic                               too_few_vertices,
    output logic                               degenerate,
    output logic                               too_many_vertices,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire        [pmp_pkg::MASS_W-1:0]   cfg_data
);
    import pmp_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // The mass register accepts a write in any cycle.
    assign cfg_ready = 1'b1;

    pmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    pmp_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .vertex_x          (vertex_x),
        .vertex_y          (vertex_y),
        .last_vertex       (last_vertex),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_data          (cfg_data),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .area              (area),
        .centroid_x        (centroid_x),
        .centroid_y        (centroid_y),
        .inertia           (inertia),
        .is_convex         (is_convex),
        .too_few_vertices  (too_few_vertices),
        .degenerate        (degenerate),
        .too_many_vertices (too_many_vertices)
    );

    // A new result is only produced while a polygon is being finished.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while the sequencer was idle");

    // An overflowed polygon reports nothing but the overflow flag.
    a_overflow_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && too_many_vertices |->
            area == '0 && inertia == '0 && !is_convex && !too_few_vertices && !degenerate)
        else $error("overflowed polygon carries values");

    // Convex needs at least three vertices.
    a_convex_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_convex |-> !too_few_vertices)
        else $error("convex flag with too few vertices");
endmodule
`default_nettype wire

@@ bench/polygon_checker.sv @@
// Checker for the polygon mass properties block: watches the vertex, result
// and mass channels, predicts each polygon's result and compares it.
// Depends on pmp_pkg for MAX_VERTICES and MASS_RESET.
`timescale 1ns / 1ps
module polygon_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic signed [13:0]          vertex_x,
    input  logic signed [13:0]          vertex_y,
    input  logic                        last_vertex,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [32:0]                 area,
    input  logic [13:0]                 centroid_x,
    input  logic [13:0]                 centroid_y,
    input  logic [47:0]                 inertia,
    input  logic                        is_convex,
    input  logic                        too_few_vertices,
    input  logic                        degenerate,
    input  logic                        too_many_vertices,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [15:0]                 cfg_data,
    output int                          errors,
    output int                          pending,
    output int                          results_seen
);
    import pmp_pkg::*;

    typedef struct {
        logic [32:0] area;
        logic [13:0] cx;
        logic [13:0] cy;
        logic [47:0] iner;
        logic        convex;
        logic        few;
        logic        degen;
        logic        many;
    } polygon_result_t;

    polygon_result_t expected_results[$];

    logic [15:0]     mass;
    longint          first_x, first_y, second_x, second_y;
    longint          prev_x, prev_y, pprev_x, pprev_y;
    int              nverts;
    longint          cross_sum, csum_x, csum_y;
    longint unsigned num_sum, den_sum;
    int              turn_ref;
    bit              convex_ok;

    assign pending = expected_results.size();

    task automatic clear_polygon();
        first_x = 0; first_y = 0; second_x = 0; second_y = 0;
        prev_x = 0; prev_y = 0; pprev_x = 0; pprev_y = 0;
        nverts = 0;
        cross_sum = 0; csum_x = 0; csum_y = 0;
        num_sum = 0; den_sum = 0;
        turn_ref = 0;
        convex_ok = 1;
    endtask

    task automatic accumulate_edge(longint ax, longint ay, longint bx, longint by);
        longint cr;
        longint dots;
        longint unsigned acr;
        cr = ax * by - bx * ay;
        dots = ax * ax + ay * ay + ax * bx + ay * by + bx * bx + by * by;
        acr = (cr < 0) ? longint'(-cr) : longint'(cr);
        cross_sum += cr;
        csum_x += (ax + bx) * cr;
        csum_y += (ay + by) * cr;
        num_sum += acr * longint'(dots);
        den_sum += acr;
    endtask

    task automatic corner_turn(longint ax, longint ay, longint bx, longint by,
                               longint cx, longint cy, bit is_first);
        longint cr;
        int s;
        cr = (bx - ax) * (cy - by) - (by - ay) * (cx - bx);
        s = (cr > 0) ? 1 : ((cr < 0) ? -1 : 0);
        if (is_first)
            turn_ref = s;
        else if (s * turn_ref < 0)
            convex_ok = 0;
    endtask

    // Quotient rounded to nearest with ties away from zero, then clamped to Q5.8.
    function automatic logic [13:0] centroid_quotient(longint n, longint d);
        longint unsigned un, ud, q;
        longint r;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = (2 * un + ud) / (2 * ud);
        r = ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
        if (r > 8191) r = 8191;
        if (r < -8192) r = -8192;
        return r[13:0];
    endfunction

    function automatic logic [47:0] inertia_quotient(logic [15:0] m,
                                                     longint unsigned num,
                                                     longint unsigned den);
        logic [131:0] prod, dv, q;
        prod = 132'(m) * 132'(num);
        dv = 132'(den) * 132'(6) * 132'(65536);
        q = (2 * prod + dv) / (2 * dv);
        if (q > 132'h0_FFFF_FFFF_FFFF) q = 132'h0_FFFF_FFFF_FFFF;
        return q[47:0];
    endfunction

    task automatic predict_vertex(longint vx, longint vy, bit is_last);
        polygon_result_t r;
        if (nverts < MAX_VERTICES) begin
            if (nverts == 0) begin
                first_x = vx; first_y = vy;
            end
            else begin
                accumulate_edge(prev_x, prev_y, vx, vy);
                if (nverts == 1) begin
                    second_x = vx; second_y = vy;
                end
                else
                    corner_turn(pprev_x, pprev_y, prev_x, prev_y, vx, vy, nverts == 2);
            end
            pprev_x = prev_x; pprev_y = prev_y;
            prev_x = vx; prev_y = vy;
            nverts++;
        end
        else
            nverts = MAX_VERTICES + 1;
        if (!is_last) return;
        r = '{default: '0};
        if (nverts > MAX_VERTICES) begin
            // An overlong polygon reports only the overflow flag.
            r.many = 1;
        end
        else begin
            accumulate_edge(prev_x, prev_y, first_x, first_y);
            if (nverts >= 3) begin
                corner_turn(pprev_x, pprev_y, prev_x, prev_y, first_x, first_y, 0);
                corner_turn(prev_x, prev_y, first_x, first_y, second_x, second_y, 0);
                r.convex = convex_ok;
            end
            else
                r.few = 1;
            r.area = 33'(((cross_sum < 0 ? -cross_sum : cross_sum) + 1) >> 1);
            if (cross_sum != 0) begin
                r.cx = centroid_quotient(csum_x, 3 * cross_sum);
                r.cy = centroid_quotient(csum_y, 3 * cross_sum);
            end
            if (den_sum == 0)
                r.degen = 1;
            else
                r.iner = inertia_quotient(mass, num_sum, den_sum);
        end
        expected_results.insert(expected_results.size(), r);
        clear_polygon();
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        polygon_result_t e;
        if (!rst_n) begin
            mass = MASS_RESET;
            clear_polygon();
            expected_results.delete();
            errors = 0;
            results_seen = 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                mass = cfg_data;
            if (in_valid && !in_stall)
                predict_vertex(longint'(vertex_x), longint'(vertex_y), last_vertex);
            if (out_valid && !out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result transaction with nothing expected, area %0h",
                             $time, area);
                end
                else begin
                    e = expected_results.pop_front();
                    check_field("area", 64'(e.area), 64'(area));
                    check_field("centroid_x", 64'(e.cx), 64'(centroid_x));
                    check_field("centroid_y", 64'(e.cy), 64'(centroid_y));
                    check_field("inertia", 64'(e.iner), 64'(inertia));
                    check_field("is_convex", 64'(e.convex), 64'(is_convex));
                    check_field("too_few_vertices", 64'(e.few), 64'(too_few_vertices));
                    check_field("degenerate", 64'(e.degen), 64'(degenerate));
                    check_field("too_many_vertices", 64'(e.many), 64'(too_many_vertices));
                end
            end
        end
    end
endmodule

@@ bench/testbench.sv @@
// Top of the polygon mass properties bench: clock, reset, vertex stimulus,
// mass writes and the verdict. Depends on pmp_pkg, the block and polygon_checker.
`timescale 1ns / 1ps
module testbench;
    import pmp_pkg::*;

    // Generous bound on the length of the run.
    localparam int CYCLE_LIMIT = 3000000;
    // Extra quiet time after the last expected result has been seen.
    localparam int DRAIN_CYCLES = 400;

    logic                clk = 0;
    logic                rst_n = 0;
    logic                in_valid = 0;
    logic                in_stall;
    logic signed [13:0]  vertex_x = 0;
    logic signed [13:0]  vertex_y = 0;
    logic                last_vertex = 0;
    logic                out_valid;
    logic                out_stall = 0;
    logic [32:0]         area;
    logic signed [13:0]  centroid_x, centroid_y;
    logic [47:0]         inertia;
    logic                is_convex, too_few_vertices, degenerate, too_many_vertices;
    logic                cfg_valid = 0;
    logic                cfg_ready;
    logic [15:0]         cfg_data = 0;

    int errors, pending, results_seen;
    int sender_gap_pct = 0;
    int receiver_stall_pct = 0;
    int hold_requests = 0;
    int vertices_sent = 0;
    int polygons_sent = 0;
    int cycles = 0;

    int poly_x[$];
    int poly_y[$];

    always #10 clk = ~clk;

    polygon_mass_properties uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .last_vertex(last_vertex),
        .out_valid(out_valid), .out_stall(out_stall),
        .area(area), .centroid_x(centroid_x), .centroid_y(centroid_y),
        .inertia(inertia), .is_convex(is_convex),
        .too_few_vertices(too_few_vertices), .degenerate(degenerate),
        .too_many_vertices(too_many_vertices),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    polygon_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .last_vertex(last_vertex),
        .out_valid(out_valid), .out_stall(out_stall),
        .area(area), .centroid_x(centroid_x), .centroid_y(centroid_y),
        .inertia(inertia), .is_convex(is_convex),
        .too_few_vertices(too_few_vertices), .degenerate(degenerate),
        .too_many_vertices(too_many_vertices),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .results_seen(results_seen)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: errors");
            $finish;
        end
    end

    // Receiver side. A long hold-off is counted here so that the result
    // register fills, the next polygon's result backs up behind it and the
    // block has to stall its vertex input.
    always @(posedge clk) begin
        int hold_left;
        int hold_seen;
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = 1500;
        end
        if (hold_left > 0)
            hold_left--;
        out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // One vertex transaction. Valid stays high across back-to-back transactions
    // and drops during a sender gap or a bench pause, so each step sees a single assignment.
    task automatic send_vertex(int x, int y, bit is_last);
        while ($urandom_range(0, 99) < sender_gap_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        vertex_x <= 14'(x);
        vertex_y <= 14'(y);
        last_vertex <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        vertices_sent++;
    endtask

    task automatic send_polygon();
        for (int i = 0; i < poly_x.size(); i++)
            send_vertex(poly_x[i], poly_y[i], i == poly_x.size() - 1);
        polygons_sent++;
        poly_x.delete();
        poly_y.delete();
    endtask

    task automatic add_vertex(int x, int y);
        poly_x.insert(poly_x.size(), x);
        poly_y.insert(poly_y.size(), y);
    endtask

    function automatic int any_coord();
        return int'($urandom_range(0, 16383)) - 8192;
    endfunction

    // Waits for the block to go quiet: every result in and the dividers done.
    task automatic wait_idle();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mass(logic [15:0] value);
        wait_idle();
        cfg_valid <= 1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // Mostly closed, well-formed shapes with random content; a few too-short
    // polygons and a rare overlong one.
    task automatic random_polygon();
        int pick, n, a, b, c, d;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            a = any_coord(); b = any_coord(); c = any_coord(); d = any_coord();
            add_vertex(a, c); add_vertex(b, c); add_vertex(b, d); add_vertex(a, d);
        end
        else if (pick < 55) begin
            for (int i = 0; i < 3; i++) add_vertex(any_coord(), any_coord());
        end
        else if (pick < 70) begin
            // Small shapes near one spot give modest areas and unsaturated centroids.
            a = any_coord() / 2; c = any_coord() / 2;
            n = $urandom_range(3, 8);
            for (int i = 0; i < n; i++)
                add_vertex(a + int'($urandom_range(0, 600)), c + int'($urandom_range(0, 600)));
        end
        else if (pick < 93) begin
            n = $urandom_range(3, 12);
            for (int i = 0; i < n; i++) add_vertex(any_coord(), any_coord());
        end
        else if (pick < 99) begin
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++) add_vertex(any_coord(), any_coord());
        end
        else begin
            n = $urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 4);
            for (int i = 0; i < n; i++) add_vertex(any_coord(), any_coord());
        end
        send_polygon();
    endtask

    task automatic random_phase(int gap_pct, int stall_pct, int vertex_target, bit pressure);
        sender_gap_pct = gap_pct;
        receiver_stall_pct = stall_pct;
        if (pressure) begin
            // Hold the receiver off while polygons keep coming.
            hold_requests++;
            for (int i = 0; i < 6; i++) begin
                add_vertex(0, 0); add_vertex(512, 0); add_vertex(0, 512);
                send_polygon();
            end
            // Then the sender pauses until every result has drained.
            in_valid <= 0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
        end
        while (vertices_sent < vertex_target)
            random_polygon();
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed shapes at the reset mass.
        add_vertex(0, 0); add_vertex(256, 0); add_vertex(256, 256); add_vertex(0, 256);
        send_polygon();                                   // counterclockwise square
        add_vertex(0, 0); add_vertex(0, 256); add_vertex(256, 256); add_vertex(256, 0);
        send_polygon();                                   // clockwise square
        add_vertex(-8192, -8192); add_vertex(8191, -8192); add_vertex(0, 8191);
        send_polygon();                                   // extreme triangle
        add_vertex(8191, 8191);
        send_polygon();                                   // a lone vertex
        add_vertex(-8192, 8191); add_vertex(8191, -8192);
        send_polygon();                                   // just two vertices
        add_vertex(0, 0); add_vertex(0, 0); add_vertex(0, 0);
        send_polygon();                                   // all at one point: no area
        add_vertex(0, 0); add_vertex(100, 0); add_vertex(200, 0); add_vertex(100, 100);
        send_polygon();                                   // straight first corner
        add_vertex(0, 0); add_vertex(400, 0); add_vertex(100, 100); add_vertex(0, 400);
        send_polygon();                                   // concave
        add_vertex(0, 0); add_vertex(100, 100); add_vertex(100, 0); add_vertex(0, 100);
        send_polygon();                                   // bow tie: areas cancel
        for (int i = 0; i < MAX_VERTICES + 2; i++)
            add_vertex(any_coord(), any_coord());
        send_polygon();                                   // more than the maximum

        write_mass(16'hFFFF);
        random_phase(14, 79, 700, 0);
        write_mass(16'h0000);
        random_phase(79, 14, 1300, 0);
        write_mass(16'($urandom_range(1, 65534)));
        random_phase(0, 0, 1950, 1);

        wait_idle();
        $display("covered %0d polygons (%0d vertices) over four mass settings;",
                 polygons_sent, vertices_sent);
        $display("%0d results checked field by field", results_seen);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
